// ----- design/refcounted_tag_cache_table_defines.svh -----
// assertion macros for the refcounted tag cache table
`ifndef REFCOUNTED_TAG_CACHE_TABLE_DEFINES_SVH
`define REFCOUNTED_TAG_CACHE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RTCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtct check failed");

// next-cycle implication, sampled on clk, off during reset
`define RTCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtct check failed");

`endif

// ----- design/rtct_pkg.sv -----
// types and constants shared by the refcounted tag cache table
package rtct_pkg;

    localparam int DEV_W  = 8;
    localparam int OBJ_W  = 16;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 16;
    localparam int STS_W  = 3;
    localparam int TAG_W  = DEV_W + OBJ_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [STS_W-1:0] ST_HIT       = 3'd0;
    localparam logic [STS_W-1:0] ST_ALLOC     = 3'd1;
    localparam logic [STS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STS_W-1:0] ST_RELEASED  = 3'd3;
    localparam logic [STS_W-1:0] ST_PUT_UNREF = 3'd4;

    typedef struct packed {
        logic              action;
        logic [DEV_W-1:0]  device_id;
        logic [OBJ_W-1:0]  object_number;
        logic [SLOT_W-1:0] release_slot;
    } req_t;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  ref_after;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_cmp;
        logic get_wr;
        logic put_rd;
        logic put_wr;
    } cmd_t;

    typedef struct packed {
        logic issued_all;
        logic hit;
        logic last;
    } sts_t;

endpackage

// ----- design/rtct_ctrl.sv -----
// controller state machine for the refcounted tag cache table
module rtct_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            action,
    input  rtct_pkg::sts_t  sts,
    output rtct_pkg::cmd_t  cmd,
    output logic            busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_PUT_RD = 5'b01000,
        S_PUT_WR = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (action == rtct_pkg::ACT_PUT) ? S_PUT_RD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_cmp = 1'b1;
                cmd.scan_rd  = !sts.issued_all;
                if (sts.hit || sts.last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.get_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_PUT_RD:
            begin
                cmd.put_rd = 1'b1;
                state_next = S_PUT_WR;
            end
            S_PUT_WR:
            begin
                cmd.put_wr = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- design/rtct_datapath.sv -----
// tag and count memories, scan compare and result register
module rtct_datapath #(
    parameter int ENTRIES = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  rtct_pkg::cmd_t  cmd,
    input  rtct_pkg::req_t  request,
    output rtct_pkg::sts_t  sts,
    output logic            done,
    output rtct_pkg::rsp_t  result
);

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);

    logic [rtct_pkg::TAG_W-1:0] tag_mem [ENTRIES];
    logic [rtct_pkg::CNT_W-1:0] cnt_mem [ENTRIES];

    logic [ENTRIES-1:0] live_reg;
    logic [ENTRIES-1:0] live_next;

    rtct_pkg::req_t             req_reg;
    logic [CW-1:0]              scan_cnt_reg;
    logic [CW-1:0]              scan_cnt_next;
    logic                       cmp_vld_reg;
    logic [rtct_pkg::TAG_W-1:0] rd_tag_reg;
    logic [rtct_pkg::CNT_W-1:0] rd_cnt_reg;
    logic                       rd_live_reg;
    logic [IDXW-1:0]            rd_idx_reg;
    logic                       hit_found_reg;
    logic                       hit_found_next;
    logic                       free_found_reg;
    logic                       free_found_next;
    logic [IDXW-1:0]            hit_idx_reg;
    logic [IDXW-1:0]            hit_idx_next;
    logic [IDXW-1:0]            free_idx_reg;
    logic [IDXW-1:0]            free_idx_next;
    logic [rtct_pkg::CNT_W-1:0] hit_cnt_reg;
    logic [rtct_pkg::CNT_W-1:0] hit_cnt_next;
    logic                       done_reg;
    logic                       done_next;
    rtct_pkg::rsp_t             result_reg;
    rtct_pkg::rsp_t             result_next;

    logic [IDXW-1:0]            rel_idx;
    logic                       rel_in_range;
    logic [IDXW-1:0]            rd_addr;
    logic                       rd_en;
    logic [rtct_pkg::TAG_W-1:0] req_tag;
    logic                       match;
    logic [rtct_pkg::CNT_W-1:0] cnt_dec;
    logic [rtct_pkg::CNT_W-1:0] cnt_inc;

    logic                       cnt_we;
    logic [IDXW-1:0]            cnt_waddr;
    logic [rtct_pkg::CNT_W-1:0] cnt_wdata;
    logic                       tag_we;

    assign rel_idx      = IDXW'(req_reg.release_slot);
    assign rel_in_range = (int'(req_reg.release_slot) < ENTRIES);
    assign req_tag      = {req_reg.device_id, req_reg.object_number};
    assign rd_en        = cmd.scan_rd || cmd.put_rd;
    assign rd_addr      = cmd.put_rd ? rel_idx : scan_cnt_reg[IDXW-1:0];
    assign match        = rd_live_reg && (rd_tag_reg == req_tag);
    assign cnt_dec      = rd_cnt_reg - 16'd1;
    assign cnt_inc      = (hit_cnt_reg == rtct_pkg::COUNT_MAX) ? hit_cnt_reg
                                                               : hit_cnt_reg + 16'd1;

    assign sts.issued_all = (scan_cnt_reg == CW'(ENTRIES));
    assign sts.hit        = cmp_vld_reg && match;
    assign sts.last       = cmp_vld_reg && (rd_idx_reg == IDXW'(ENTRIES - 1));

    always_comb
    begin
        scan_cnt_next   = scan_cnt_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        live_next       = live_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        cnt_we          = 1'b0;
        cnt_waddr       = hit_idx_reg;
        cnt_wdata       = cnt_inc;
        tag_we          = 1'b0;

        if (cmd.load)
        begin
            scan_cnt_next   = '0;
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end

        if (cmd.scan_rd)
        begin
            scan_cnt_next = scan_cnt_reg + CW'(1);
        end

        if (cmd.scan_cmp && cmp_vld_reg)
        begin
            if (match && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = rd_idx_reg;
                hit_cnt_next   = rd_cnt_reg;
            end
            if (!rd_live_reg && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
        end

        if (cmd.get_wr)
        begin
            done_next = 1'b1;
            if (hit_found_reg)
            begin
                cnt_we      = 1'b1;
                cnt_waddr   = hit_idx_reg;
                cnt_wdata   = cnt_inc;
                result_next = '{status: rtct_pkg::ST_HIT,
                                slot: rtct_pkg::SLOT_W'(hit_idx_reg),
                                ref_after: cnt_inc};
            end
            else if (free_found_reg)
            begin
                cnt_we                  = 1'b1;
                tag_we                  = 1'b1;
                cnt_waddr               = free_idx_reg;
                cnt_wdata               = 16'd1;
                live_next[free_idx_reg] = 1'b1;
                result_next = '{status: rtct_pkg::ST_ALLOC,
                                slot: rtct_pkg::SLOT_W'(free_idx_reg),
                                ref_after: 16'd1};
            end
            else
            begin
                result_next = '{status: rtct_pkg::ST_FULL, slot: '0, ref_after: '0};
            end
        end

        if (cmd.put_wr)
        begin
            done_next = 1'b1;
            if (rel_in_range && rd_live_reg)
            begin
                cnt_we    = 1'b1;
                cnt_waddr = rel_idx;
                cnt_wdata = cnt_dec;
                if (cnt_dec == '0)
                begin
                    live_next[rel_idx] = 1'b0;
                end
                result_next = '{status: rtct_pkg::ST_RELEASED,
                                slot: req_reg.release_slot,
                                ref_after: cnt_dec};
            end
            else
            begin
                result_next = '{status: rtct_pkg::ST_PUT_UNREF,
                                slot: req_reg.release_slot,
                                ref_after: '0};
            end
        end
    end

    // memories and read port
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (tag_we)
        begin
            tag_mem[free_idx_reg] <= req_tag;
        end
        if (rd_en)
        begin
            rd_tag_reg  <= tag_mem[rd_addr];
            rd_cnt_reg  <= cnt_mem[rd_addr];
            rd_live_reg <= live_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        result_reg   <= result_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= '0;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            live_reg       <= live_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmd.scan_rd;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            done_reg       <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- design/refcounted_tag_cache_table.sv -----
// top level of the refcounted tag cache table
//
// Command channel: drive request and raise start; the word is taken at the
// clock edge where start is high and busy is low. Each request gives exactly
// one result word on result, shown for one cycle with done high. The receiver
// cannot stall the result port; it must take the word in that cycle.
// A get walks the tag and count memories one entry per cycle through a
// registered read port, stopping at the first live entry with a matching tag
// or after the last entry; the update state then writes the count and the
// result. A put reads the count, then decrements and writes it back. One
// request is in flight at a time; busy is low again in the cycle that done
// shows, so the next start can be taken there.
// Reset clears every entry's live flag at once, so every entry counts as free
// right after reset, though the count memory is not cleared; there is no
// clearing pass.
module refcounted_tag_cache_table #(
    parameter int ENTRIES = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  rtct_pkg::req_t  request,
    output logic            done,
    output rtct_pkg::rsp_t  result
);

    rtct_pkg::cmd_t cmd;
    rtct_pkg::sts_t sts;

    rtct_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    rtct_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule

// ----- design/rtct_checker.sv -----
// port-level checks for the refcounted tag cache table
`include "refcounted_tag_cache_table_defines.svh"

module rtct_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input rtct_pkg::rsp_t  result
);

    `RTCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `RTCT_ASSERT_NEXT(a_done_single, done, !done)
    `RTCT_ASSERT_NOW(a_full_zero, done && (result.status == rtct_pkg::ST_FULL),
        (result.slot == '0) && (result.ref_after == '0))
    `RTCT_ASSERT_NOW(a_alloc_one, done && (result.status == rtct_pkg::ST_ALLOC),
        result.ref_after == 16'd1)
    `RTCT_ASSERT_NOW(a_unref_zero, done && (result.status == rtct_pkg::ST_PUT_UNREF),
        result.ref_after == '0)

endmodule

bind refcounted_tag_cache_table rtct_checker u_rtct_checker (.*);

// ----- sim/refcounted_tag_cache_table_tb.sv -----
// self-checking testbench for the refcounted tag cache table
module refcounted_tag_cache_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 64;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int BATCH = 16;
    localparam int BATCHES = 48;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rtct_pkg::req_t request = '0;
    logic done;
    rtct_pkg::rsp_t result;

    rtct_pkg::req_t queued_requests[$];
    rtct_pkg::rsp_t due_results[$];
    int mismatches = 0;
    int gap_pct = 22;
    int unsigned cycle_count = 0;

    logic [rtct_pkg::CNT_W-1:0] live_count [ENTRIES] = '{default: '0};
    logic [rtct_pkg::DEV_W-1:0] tag_dev [ENTRIES];
    logic [rtct_pkg::OBJ_W-1:0] tag_obj [ENTRIES];
    logic [rtct_pkg::DEV_W-1:0] dev_pool [4];
    logic [rtct_pkg::OBJ_W-1:0] obj_pool [24];

    refcounted_tag_cache_table #(.ENTRIES(ENTRIES)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // lookup, allocate or release on the shadow copy of the table
    function automatic rtct_pkg::rsp_t tag_table_access(rtct_pkg::req_t rq);
        rtct_pkg::rsp_t rs;
        int hit_at;
        int free_at;
        rs = '0;
        hit_at = -1;
        free_at = -1;
        if (rq.action == rtct_pkg::ACT_PUT)
        begin
            rs.slot = rq.release_slot;
            if (int'(rq.release_slot) >= ENTRIES || live_count[rq.release_slot] == '0)
            begin
                rs.status = rtct_pkg::ST_PUT_UNREF;
            end
            else
            begin
                live_count[rq.release_slot] = live_count[rq.release_slot] - 1'b1;
                rs.status = rtct_pkg::ST_RELEASED;
                rs.ref_after = live_count[rq.release_slot];
            end
            return rs;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_at < 0 && live_count[i] != '0 && tag_dev[i] == rq.device_id
                && tag_obj[i] == rq.object_number)
                hit_at = i;
            if (free_at < 0 && live_count[i] == '0)
                free_at = i;
        end
        if (hit_at >= 0)
        begin
            if (live_count[hit_at] != rtct_pkg::COUNT_MAX)
                live_count[hit_at] = live_count[hit_at] + 1'b1;
            rs.status = rtct_pkg::ST_HIT;
            rs.slot = rtct_pkg::SLOT_W'(hit_at);
            rs.ref_after = live_count[hit_at];
        end
        else if (free_at >= 0)
        begin
            tag_dev[free_at] = rq.device_id;
            tag_obj[free_at] = rq.object_number;
            live_count[free_at] = rtct_pkg::CNT_W'(1);
            rs.status = rtct_pkg::ST_ALLOC;
            rs.slot = rtct_pkg::SLOT_W'(free_at);
            rs.ref_after = rtct_pkg::CNT_W'(1);
        end
        else
        begin
            rs.status = rtct_pkg::ST_FULL;
        end
        return rs;
    endfunction

    function automatic rtct_pkg::req_t get_word(logic [rtct_pkg::DEV_W-1:0] dev,
                                                logic [rtct_pkg::OBJ_W-1:0] obj);
        rtct_pkg::req_t rq;
        rq.action = rtct_pkg::ACT_GET;
        rq.device_id = dev;
        rq.object_number = obj;
        rq.release_slot = rtct_pkg::SLOT_W'($urandom);
        return rq;
    endfunction

    function automatic rtct_pkg::req_t put_word(logic [rtct_pkg::SLOT_W-1:0] slot);
        rtct_pkg::req_t rq;
        rq.action = rtct_pkg::ACT_PUT;
        rq.device_id = rtct_pkg::DEV_W'($urandom);
        rq.object_number = rtct_pkg::OBJ_W'($urandom);
        rq.release_slot = slot;
        return rq;
    endfunction

    task automatic queue_random_batch(int n, int get_pct);
        int live_slots[$];
        rtct_pkg::req_t rq;
        for (int i = 0; i < ENTRIES; i++)
            if (live_count[i] != '0)
                live_slots.push_back(i);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < get_pct)
            begin
                if ($urandom_range(3) != 0)
                    rq = get_word(dev_pool[$urandom_range(3)], obj_pool[$urandom_range(23)]);
                else
                    rq = get_word(rtct_pkg::DEV_W'($urandom), rtct_pkg::OBJ_W'($urandom));
            end
            else if (live_slots.size() != 0 && $urandom_range(9) != 0)
                rq = put_word(rtct_pkg::SLOT_W'(
                         live_slots[$urandom_range(live_slots.size() - 1)]));
            else
                rq = put_word(rtct_pkg::SLOT_W'($urandom));
            queued_requests.push_back(rq);
        end
    endtask

    task automatic wait_idle();
        while (queued_requests.size() != 0 || start || due_results.size() != 0)
            @(posedge clk);
    endtask

    // driver: a word is taken at an edge with start high and busy low
    always @(posedge clk or negedge rst_n)
    begin
        logic hold;
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
        end
        else
        begin
            hold = start && busy;
            if (start && !busy)
                due_results.push_back(tag_table_access(request));
            if (!hold)
            begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    start <= 1'b1;
                    request <= queued_requests.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rtct_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: expected none, got status %0d slot %0d refs %0d",
                         $time, result.status, result.slot, result.ref_after);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (result.status !== want.status || result.slot !== want.slot
                    || result.ref_after !== want.ref_after)
                begin
                    $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $time, want.status, want.slot, want.ref_after,
                             result.status, result.slot, result.ref_after);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("refcounted_tag_cache_table_tb: errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 4; i++)
            dev_pool[i] = rtct_pkg::DEV_W'($urandom);
        for (int i = 0; i < 24; i++)
            obj_pool[i] = rtct_pkg::OBJ_W'($urandom);
        wait (rst_n);
        @(posedge clk);

        // empty table, extremes of the tag, reuse of released entries
        queued_requests.push_back(put_word(rtct_pkg::SLOT_W'(0)));
        queued_requests.push_back(put_word(rtct_pkg::SLOT_W'(ENTRIES - 1)));
        queued_requests.push_back(get_word('0, '0));
        queued_requests.push_back(get_word('1, '1));
        queued_requests.push_back(get_word('0, '0));
        queued_requests.push_back(get_word('1, '0));
        queued_requests.push_back(get_word('0, '1));
        queued_requests.push_back(put_word(rtct_pkg::SLOT_W'(0)));
        queued_requests.push_back(put_word(rtct_pkg::SLOT_W'(0)));
        queued_requests.push_back(put_word(rtct_pkg::SLOT_W'(0)));
        queued_requests.push_back(put_word(rtct_pkg::SLOT_W'(1)));
        queued_requests.push_back(get_word('0, '0));
        queued_requests.push_back(get_word('1, '1));
        queued_requests.push_back(get_word('0, '1));
        queued_requests.push_back(put_word(rtct_pkg::SLOT_W'(3)));
        wait_idle();

        for (int b = 0; b < BATCHES; b++)
        begin
            gap_pct = (b < BATCHES / 2) ? 22 : 49;
            queue_random_batch(BATCH, (b % 15) < 10 ? 90 : 25);
            wait_idle();
        end

        // fill every free entry, run into a full table, then reuse a slot
        gap_pct = 0;
        for (int i = 0; i < ENTRIES + 4; i++)
            queued_requests.push_back(get_word(8'hA5, rtct_pkg::OBJ_W'(i)));
        queued_requests.push_back(get_word(8'hA5, 16'h0000));
        queued_requests.push_back(put_word(rtct_pkg::SLOT_W'(5)));
        queued_requests.push_back(get_word(8'hA5, 16'h2000));
        queued_requests.push_back(get_word(8'hA5, 16'h3000));
        wait_idle();

        repeat (ENTRIES + 8) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("refcounted_tag_cache_table_tb: clean");
        else
            $display("refcounted_tag_cache_table_tb: errors");
        $finish;
    end

endmodule
